### design/cdq_pkg.sv
// Shared types for the coordinate deque: operation and status codes,
// controller state encoding and the controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps

package cdq_pkg;

   typedef enum logic [1:0] {
      MODE_PUSH_REAR  = 2'd0,
      MODE_PUSH_FRONT = 2'd1,
      MODE_POP_FRONT  = 2'd2,
      MODE_POP_REAR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_READ = 2'b10
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;     // an input beat is accepted this cycle
      logic finish;   // the pop read data is ready to be loaded
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free; // the result register is empty or being drained
      logic pop_ok;   // the offered item is a pop on a non-empty deque
   } stat_type;

endpackage

### design/cdq_ctrl.sv
// Controller for the coordinate deque: accepts request beats and
// sequences the registered memory read of a pop. Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_ctrl
   import cdq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   assign req_ready  = (state_ff == ST_IDLE) && stat.out_free;
   assign cmd.take   = req_valid && req_ready;
   assign cmd.finish = (state_ff == ST_READ);

   always_comb begin
      unique case (state_ff)
         ST_IDLE: begin
            state_in = (cmd.take && stat.pop_ok) ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/cdq_datapath.sv
// Datapath for the coordinate deque: ring pointers, pair memory with a
// registered read port, and the result register. Depends on cdq_pkg.
`timescale 1ns / 1ps

module cdq_datapath
   import cdq_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output stat_type                      stat,
   input  logic [1:0]                    req_mode,
   input  logic signed [COORD_BITS-1:0]  req_x_coord,
   input  logic signed [COORD_BITS-1:0]  req_y_coord,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic signed [COORD_BITS-1:0]  rsp_out_x,
   output logic signed [COORD_BITS-1:0]  rsp_out_y,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_fill_count,
   output logic                          rsp_is_empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int DW = 2 * COORD_BITS;

   logic [DW-1:0] pair_store_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   logic [AW-1:0] front_ff, front_in;
   logic [CW-1:0] count_ff, count_in;

   logic                         rsp_valid_ff;
   status_type                   rsp_status_ff;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [CW-1:0]                rsp_count_ff;
   logic                         rsp_empty_ff;

   mode_type      mode;
   status_type    status_in;
   logic          full, empty;
   logic [SW-1:0] sum, sum_m1;
   logic [AW-1:0] rear_pos, last_pos, front_dec, front_inc;
   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;

   assign mode  = mode_type'(req_mode);
   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   // Ring positions: the sum stays below twice the depth, so one
   // compare and subtract wraps it.
   assign sum       = SW'(front_ff) + SW'(count_ff);
   assign sum_m1    = sum - SW'(1);
   assign rear_pos  = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);
   assign last_pos  = (sum_m1 >= SW'(DEPTH)) ? AW'(sum_m1 - SW'(DEPTH)) : AW'(sum_m1);
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : front_ff - AW'(1);
   assign front_inc = (front_ff == AW'(DEPTH - 1)) ? '0 : front_ff + AW'(1);

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.pop_ok   = req_mode[1] && !empty;

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = STATUS_DONE;
      wr_en     = 1'b0;
      wr_addr   = rear_pos;
      rd_en     = 1'b0;
      rd_addr   = front_ff;
      unique case (mode)
         MODE_PUSH_REAR: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = cmd.take;
               wr_addr  = rear_pos;
               count_in = count_ff + CW'(1);
            end
         end
         MODE_PUSH_FRONT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               wr_en    = cmd.take;
               wr_addr  = front_dec;
               front_in = front_dec;
               count_in = count_ff + CW'(1);
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en    = cmd.take;
               rd_addr  = front_ff;
               front_in = front_inc;
               count_in = count_ff - CW'(1);
            end
         end
         MODE_POP_REAR: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               rd_en    = cmd.take;
               rd_addr  = last_pos;
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            status_in = STATUS_DONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pair_store_ff[wr_addr] <= {req_y_coord, req_x_coord};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= pair_store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.take) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
         if ((cmd.take && !stat.pop_ok) || cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: pops get their pair in the cycle after the beat,
   // when the memory read data has been registered.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         rsp_status_ff <= status_in;
         rsp_x_ff      <= '0;
         rsp_y_ff      <= '0;
         rsp_count_ff  <= count_in;
         rsp_empty_ff  <= (count_in == '0);
      end else if (cmd.finish) begin
         rsp_x_ff <= $signed(rd_data_ff[COORD_BITS-1:0]);
         rsp_y_ff <= $signed(rd_data_ff[DW-1:COORD_BITS]);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_x      = rsp_x_ff;
   assign rsp_out_y      = rsp_y_ff;
   assign rsp_fill_count = rsp_count_ff;
   assign rsp_is_empty   = rsp_empty_ff;

endmodule

### design/coordinate_deque_top.sv
// Top level of the coordinate deque: joins the controller and the datapath.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
`timescale 1ns / 1ps

// Double-ended queue of signed (x, y) pairs held in a ring buffer of DEPTH
// entries. Each request beat pushes at the rear or front, or pops from the
// front or rear, and yields exactly one response beat with the status, the
// popped pair (zero for pushes and refused operations), the fill count and
// an empty flag. A successful pop holds off the next request while its
// pair is read, because the pair memory has a registered read port. A new
// request is taken while no pop read is pending and the response register
// is free or being drained in the same cycle. No clearing pass is needed
// after reset: only entries that hold stored pairs are ever read.
module coordinate_deque_top
   import cdq_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_mode,
   input  logic signed [COORD_BITS-1:0]  req_x_coord,
   input  logic signed [COORD_BITS-1:0]  req_y_coord,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic signed [COORD_BITS-1:0]  rsp_out_x,
   output logic signed [COORD_BITS-1:0]  rsp_out_y,
   output logic [$clog2(DEPTH+1)-1:0]    rsp_fill_count,
   output logic                          rsp_is_empty
);

   cmd_type  cmd;
   stat_type stat;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cdq_datapath #(
      .DEPTH      (DEPTH),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_mode       (req_mode),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_fill_count (rsp_fill_count),
      .rsp_is_empty   (rsp_is_empty)
   );

`ifndef SYNTHESIS
   // A request beat is only taken when the response register can be reused.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!rsp_valid || rsp_ready))
      else $error("request beat taken while response register is blocked");

   // The empty flag agrees with the fill count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_fill_count == '0)))
      else $error("empty flag disagrees with fill count");

   // Refused operations return a zero pair.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_DONE)) |->
         ((rsp_out_x == '0) && (rsp_out_y == '0)))
      else $error("refused operation returned a nonzero pair");

   // The fill count never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_fill_count <= ($clog2(DEPTH+1))'(DEPTH)))
      else $error("fill count exceeds capacity");
`endif

endmodule

### tb/sv/coordinate_deque_checker.sv
// Response checker for the coordinate deque: keeps its own ring of pairs,
// predicts one reply per accepted request beat and compares reply beats.
// Depends on cdq_pkg.
`timescale 1ns / 1ps

module coordinate_deque_checker
   import cdq_pkg::*;
#(
   parameter int DEPTH      = 256,
   parameter int COORD_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [1:0]                      req_mode,
   input  logic signed [COORD_BITS-1:0]    req_x_coord,
   input  logic signed [COORD_BITS-1:0]    req_y_coord,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [1:0]                      rsp_status,
   input  logic signed [COORD_BITS-1:0]    rsp_out_x,
   input  logic signed [COORD_BITS-1:0]    rsp_out_y,
   input  logic [$clog2(DEPTH+1)-1:0]      rsp_fill_count,
   input  logic                            rsp_is_empty,
   output int                              failure_count,
   output int                              pending_count
);

   localparam int CW = $clog2(DEPTH + 1);

   typedef struct packed {
      status_type            status;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [CW-1:0]         fill;
      logic                  empty;
   } deque_reply_type;

   logic [COORD_BITS-1:0] ring_x [DEPTH];
   logic [COORD_BITS-1:0] ring_y [DEPTH];
   int                    ring_head;
   int                    ring_fill;
   int                    reply_beats;
   deque_reply_type       expected_replies [$];

   initial begin
      failure_count = 0;
      pending_count = 0;
      reply_beats   = 0;
      ring_head     = 0;
      ring_fill     = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR: reply beat %0d: %s", reply_beats, msg);
      failure_count++;
   endtask

   // Applies one operation to the local ring and queues the reply it must give.
   task automatic predict_operation(input mode_type op, input logic [COORD_BITS-1:0] x,
                                    input logic [COORD_BITS-1:0] y);
      deque_reply_type r;
      int              slot;
      r        = '0;
      r.status = STATUS_DONE;
      slot     = 0;
      case (op)
         MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
            if (ring_fill >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               if (op == MODE_PUSH_REAR) begin
                  slot = (ring_head + ring_fill) % DEPTH;
               end else begin
                  ring_head = (ring_head + DEPTH - 1) % DEPTH;
                  slot      = ring_head;
               end
               ring_x[slot] = x;
               ring_y[slot] = y;
               ring_fill++;
            end
         end
         default: begin
            if (ring_fill == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               if (op == MODE_POP_FRONT) begin
                  slot      = ring_head;
                  ring_head = (ring_head + 1) % DEPTH;
               end else begin
                  slot = (ring_head + ring_fill - 1) % DEPTH;
               end
               r.x = ring_x[slot];
               r.y = ring_y[slot];
               ring_fill--;
            end
         end
      endcase
      r.fill  = CW'(ring_fill);
      r.empty = (ring_fill == 0);
      expected_replies.push_back(r);
   endtask

   task automatic check_reply();
      deque_reply_type want;
      reply_beats++;
      if (expected_replies.size() == 0) begin
         report_mismatch("reply beat with no request outstanding");
      end else begin
         want = expected_replies.pop_front();
         if (rsp_status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d", rsp_status, want.status));
         if (rsp_out_x !== want.x)
            report_mismatch($sformatf("out_x got %0d expected %0d",
                                      rsp_out_x, $signed(want.x)));
         if (rsp_out_y !== want.y)
            report_mismatch($sformatf("out_y got %0d expected %0d",
                                      rsp_out_y, $signed(want.y)));
         if (rsp_fill_count !== want.fill)
            report_mismatch($sformatf("fill_count got %0d expected %0d",
                                      rsp_fill_count, want.fill));
         if (rsp_is_empty !== want.empty)
            report_mismatch($sformatf("is_empty got %0d expected %0d",
                                      rsp_is_empty, want.empty));
      end
   endtask

   // A reply leaving at this edge always belongs to an earlier request, so the
   // comparison runs before the new request beat is predicted.
   always @(posedge clock) begin
      if (reset) begin
         ring_head = 0;
         ring_fill = 0;
         expected_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready)
            check_reply();
         if (req_valid && req_ready)
            predict_operation(mode_type'(req_mode), req_x_coord, req_y_coord);
      end
      pending_count = expected_replies.size();
   end

endmodule

### tb/sv/coordinate_deque_top_test.sv
// Testbench top for the coordinate deque: clock, reset, request and reply
// stimulus with random idling, and the final verdict.
// Depends on cdq_pkg, coordinate_deque_top and coordinate_deque_checker.
`timescale 1ns / 1ps

module coordinate_deque_top_test;
   import cdq_pkg::*;

   localparam int DEPTH        = 256;
   localparam int COORD_BITS   = 16;
   localparam int CW           = $clog2(DEPTH + 1);
   localparam int RANDOM_BEATS = 750;
   localparam int CHUNK_BEATS  = 25;
   localparam int CALM_FROM    = 650;
   localparam int HOLD_AT      = 200;
   localparam int HOLD_CYCLES  = 80;

   typedef enum {MIX_BALANCED, MIX_FILL, MIX_DRAIN} op_mix_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [1:0]                    req_mode;
   logic signed [COORD_BITS-1:0]  req_x_coord;
   logic signed [COORD_BITS-1:0]  req_y_coord;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic [1:0]                    rsp_status;
   logic signed [COORD_BITS-1:0]  rsp_out_x;
   logic signed [COORD_BITS-1:0]  rsp_out_y;
   logic [CW-1:0]                 rsp_fill_count;
   logic                          rsp_is_empty;
   int                            failure_count;
   int                            pending_count;

   bit sender_idles   = 1'b0;
   bit receiver_idles = 1'b0;
   bit calm           = 1'b0;
   bit hold_requested = 1'b0;

   always #5 clock = ~clock;

   coordinate_deque_top #(
      .DEPTH      (DEPTH),
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_fill_count (rsp_fill_count),
      .rsp_is_empty   (rsp_is_empty)
   );

   coordinate_deque_checker #(
      .DEPTH      (DEPTH),
      .COORD_BITS (COORD_BITS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_fill_count (rsp_fill_count),
      .rsp_is_empty   (rsp_is_empty),
      .failure_count  (failure_count),
      .pending_count  (pending_count)
   );

   function automatic logic [COORD_BITS-1:0] random_coord();
      case ($urandom_range(0, 7))
         0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
         1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return COORD_BITS'($urandom());
      endcase
   endfunction

   function automatic mode_type pick_mode(input op_mix_type mix);
      int push_odds;
      push_odds = (mix == MIX_FILL) ? 31 : (mix == MIX_DRAIN) ? 1 : 16;
      if ($urandom_range(0, 31) < push_odds)
         return $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
      return $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_REAR;
   endfunction

   // Offers one request beat and returns once it is taken. Valid stays high
   // into the next beat unless an idle burst follows.
   task automatic send_beat(input mode_type op, input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y);
      req_valid   <= 1'b1;
      req_mode    <= op;
      req_x_coord <= x;
      req_y_coord <= y;
      do @(posedge clock); while (!req_ready);
      if (!calm && sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Reply side: random stall bursts, plus one long hold-off while requests
   // keep coming so that the block backs up and stalls its input.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         if (hold_requested) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_requested = 1'b0;
         end else if (!calm && receiver_idles && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      op_mix_type mix;
      int         drain_wait;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_mode    = MODE_PUSH_REAR;
      req_x_coord = '0;
      req_y_coord = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: refused pops on an empty deque, extreme coordinates,
      // a push at the front that wraps the head, and pops from both ends.
      send_beat(MODE_POP_FRONT, random_coord(), random_coord());
      send_beat(MODE_POP_REAR, random_coord(), random_coord());
      send_beat(MODE_PUSH_REAR, 16'h8000, 16'h7FFF);
      send_beat(MODE_PUSH_FRONT, 16'h7FFF, 16'h8000);
      send_beat(MODE_PUSH_REAR, 16'h0000, 16'hFFFF);
      send_beat(MODE_PUSH_FRONT, 16'hFFFF, 16'h0000);
      send_beat(MODE_POP_FRONT, 16'h1234, 16'h5678);
      send_beat(MODE_POP_REAR, random_coord(), random_coord());
      send_beat(MODE_POP_REAR, random_coord(), random_coord());
      send_beat(MODE_POP_FRONT, random_coord(), random_coord());
      send_beat(MODE_POP_FRONT, random_coord(), random_coord());
      send_beat(MODE_PUSH_REAR, 16'h5555, 16'hAAAA);
      send_beat(MODE_PUSH_FRONT, 16'hAAAA, 16'h5555);
      send_beat(MODE_POP_REAR, random_coord(), random_coord());
      send_beat(MODE_POP_REAR, random_coord(), random_coord());
      send_beat(MODE_POP_REAR, random_coord(), random_coord());

      // Random beats: a long push-heavy stretch runs the deque into full, a
      // pop-heavy one runs it back to empty, with balanced stretches between.
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % CHUNK_BEATS == 0) begin
            sender_idles   = $urandom_range(0, 1);
            receiver_idles = $urandom_range(0, 1);
         end
         calm = (i >= CALM_FROM);
         if (i == HOLD_AT)
            hold_requested = 1'b1;
         if (i >= 60 && i < 360)
            mix = MIX_FILL;
         else if (i >= 420 && i < 720)
            mix = MIX_DRAIN;
         else
            mix = MIX_BALANCED;
         send_beat(pick_mode(mix), random_coord(), random_coord());
      end
      req_valid <= 1'b0;

      drain_wait = 0;
      do begin
         @(negedge clock);
         drain_wait++;
      end while (pending_count != 0 && drain_wait < 2000);
      repeat (4) @(negedge clock);

      if (pending_count != 0)
         $display("ERROR: %0d replies never arrived", pending_count);
      if (failure_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### coordinate_deque_top.f
design/cdq_pkg.sv
design/cdq_ctrl.sv
design/cdq_datapath.sv
design/coordinate_deque_top.sv
tb/sv/coordinate_deque_checker.sv
tb/sv/coordinate_deque_top_test.sv
